// ===== src/modbus_single_coil_responder_unit_defines.svh =====
// Assertion macros shared by the Modbus single coil responder modules.
`ifndef MODBUS_SINGLE_COIL_RESPONDER_UNIT_DEFINES_SVH
`define MODBUS_SINGLE_COIL_RESPONDER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MSR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msr: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define MSR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msr: next-cycle check failed");

`endif

// ===== src/msr_pkg.sv =====
// Types, constants and CRC helper for the Modbus single coil responder.
`timescale 1ns / 1ps

package msr_pkg;

  localparam int HDR_DEPTH = 9;
  localparam int HDR_IDX_W = $clog2(HDR_DEPTH);
  localparam logic [3:0] COUNT_MAX = 4'd15;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [3:0] MIN_LEN = 4'd4;
  localparam logic [3:0] STD_LEN = 4'd8;
  localparam logic [3:0] MULTI_LEN = 4'd11;

  localparam logic [7:0] FC_READ_COILS = 8'h01;
  localparam logic [7:0] FC_READ_HOLD = 8'h03;
  localparam logic [7:0] FC_WRITE_COIL = 8'h05;
  localparam logic [7:0] FC_WRITE_REG = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI = 8'h10;

  localparam logic [15:0] COIL_ON = 16'hFF00;
  localparam logic [15:0] COIL_OFF = 16'h0000;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] SLAVE_ADDR_RESET = 8'd2;

  // one queued reply: up to eight bytes, CRC inserted at crc_idx when has_crc
  typedef struct packed {
    logic [7:0][7:0] data;
    logic [2:0]      last_idx;
    logic            has_crc;
    logic [2:0]      crc_idx;
    logic            coil;
  } msr_cmd_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/msr_channels_if.sv =====
// Channel interfaces of the Modbus single coil responder: request, reply, config.
`timescale 1ns / 1ps

interface msr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_last;
  modport source (output valid, output rx_byte, output rx_last, input ready);
  modport sink (input valid, input rx_byte, input rx_last, output ready);
endinterface

interface msr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic       coil_level;
  modport source (output valid, output tx_byte, output tx_last, output coil_level,
                  input ready);
  modport sink (input valid, input tx_byte, input tx_last, input coil_level,
                output ready);
endinterface

interface msr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/modbus_single_coil_responder_unit.sv =====
// Top level of the Modbus single coil responder.
`timescale 1ns / 1ps
// Usage:
//   in_ch  : request bytes, rx_last on the final byte of a frame. One byte is
//            taken per cycle; in_ch.ready drops only while the reply queue
//            (two frames deep) is full.
//   out_ch : reply bytes, tx_last on the final byte, coil_level with each byte.
//   cfg_ch : slave address write, taken in any cycle; write it only while idle.
// Reply path: after the last request byte is transferred, the first reply byte
//   passes the queue slot, the current-reply register and the output register;
//   the rest follow one per cycle while out_ch.ready is high. Replies are 6 to 8
//   bytes; the queue decouples a frame's decode from the previous frame's reply.
// Frames that get no reply push nothing and leave the coil unchanged.
// Reset: rst_n low clears the byte count, the coil, the queue and the output
//   register, and sets the slave address to 2.
// Stall: a low out_ch.ready holds the output register; the emitter, then the
//   queue, then in_ch.ready back up in turn.

module modbus_single_coil_responder_unit (
  input  logic       clk,
  input  logic       rst_n,
  msr_in_if.sink     in_ch,
  msr_out_if.source  out_ch,
  msr_cfg_if.sink    cfg_ch
);
  import msr_pkg::*;

  msr_cmd_t push_cmd;
  msr_cmd_t pop_cmd;
  logic     push, pop, full, not_empty;

  msr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .cmd_full (full),
    .cmd_push (push),
    .cmd      (push_cmd)
  );

  msr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_cmd   (pop_cmd)
  );

  msr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (not_empty),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== src/msr_front.sv =====
// Front end: collects request bytes, decodes the frame and queues the reply.
`timescale 1ns / 1ps

module msr_front (
  input  logic              clk,
  input  logic              rst_n,
  msr_in_if.sink            in_ch,
  msr_cfg_if.sink           cfg_ch,
  input  logic              cmd_full,
  output logic              cmd_push,
  output msr_pkg::msr_cmd_t cmd
);
  import msr_pkg::*;

  logic [7:0] hdr_r [HDR_DEPTH];
  logic [7:0] view [HDR_DEPTH];
  logic [3:0] count_r, count_nxt;
  logic       coil_r, coil_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [3:0] len;
  logic [7:0] fc;
  logic [15:0] v45, v78;
  logic       accept, addr_ok, reply;

  assign in_ch.ready = !cmd_full;
  assign cfg_ch.ready = 1'b1;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    for (int i = 0; i < HDR_DEPTH; i++) begin
      view[i] = (count_r == 4'(i)) ? in_ch.rx_byte : hdr_r[i];
    end
  end

  assign len = (count_r == COUNT_MAX) ? COUNT_MAX : count_r + 4'd1;
  assign fc = view[1];
  assign v45 = {view[4], view[5]};
  assign v78 = {view[7], view[8]};
  assign addr_ok = (len >= MIN_LEN) && (view[0] == addr_r);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cmd.data[i] = view[i];
    end
    cmd.last_idx = 3'd7;
    cmd.has_crc = 1'b0;
    cmd.crc_idx = 3'd0;
    reply = 1'b0;
    coil_nxt = coil_r;
    if (addr_ok) begin
      priority if (fc == FC_WRITE_COIL && len >= STD_LEN) begin
        reply = 1'b1;
        if (v45 == COIL_ON) begin
          coil_nxt = 1'b1;
        end else if (v45 == COIL_OFF) begin
          coil_nxt = 1'b0;
        end
      end else if (fc == FC_WRITE_REG && len >= STD_LEN) begin
        reply = 1'b1;
        coil_nxt = (v45 != 16'h0000);
      end else if (fc == FC_WRITE_MULTI && len >= MULTI_LEN) begin
        reply = 1'b1;
        coil_nxt = (v78 != 16'h0000);
        cmd.has_crc = 1'b1;
        cmd.crc_idx = 3'd6;
        cmd.last_idx = 3'd7;
      end else if (fc == FC_READ_COILS && len >= STD_LEN) begin
        reply = 1'b1;
        cmd.data[0] = addr_r;
        cmd.data[1] = FC_READ_COILS;
        cmd.data[2] = 8'd1;
        cmd.data[3] = {7'd0, coil_r};
        cmd.has_crc = 1'b1;
        cmd.crc_idx = 3'd4;
        cmd.last_idx = 3'd5;
      end else if (fc == FC_READ_HOLD && len >= STD_LEN) begin
        reply = 1'b1;
        cmd.data[0] = addr_r;
        cmd.data[1] = FC_READ_HOLD;
        cmd.data[2] = 8'd2;
        cmd.data[3] = 8'd0;
        cmd.data[4] = {7'd0, coil_r};
        cmd.has_crc = 1'b1;
        cmd.crc_idx = 3'd5;
        cmd.last_idx = 3'd6;
      end else begin
        reply = 1'b0;
      end
    end
    cmd.coil = coil_nxt;
  end

  assign cmd_push = accept && in_ch.rx_last && reply;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = in_ch.rx_last ? 4'd0 : len;
    end
    addr_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.data : addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 4'd0;
      coil_r <= 1'b0;
      addr_r <= SLAVE_ADDR_RESET;
    end else begin
      count_r <= count_nxt;
      addr_r <= addr_nxt;
      if (cmd_push) begin
        coil_r <= coil_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && count_r < 4'(HDR_DEPTH)) begin
      hdr_r[count_r[HDR_IDX_W-1:0]] <= in_ch.rx_byte;
    end
  end

endmodule

// ===== src/msr_queue.sv =====
// Short reply queue between the decoding front end and the byte emitter.
`timescale 1ns / 1ps
`include "modbus_single_coil_responder_unit_defines.svh"

module msr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  msr_pkg::msr_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output msr_pkg::msr_cmd_t pop_cmd
);
  import msr_pkg::*;

  msr_cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]     count_r, count_nxt;

  assign full = (count_r == QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  `MSR_ASSERT_IMP(a_no_overflow, push, !full || pop)
  `MSR_ASSERT_IMP(a_no_underflow, pop, not_empty)
  `MSR_ASSERT_NXT(a_push_fills, push && !pop, not_empty)

endmodule

// ===== src/msr_back.sv =====
// Back end: emits queued reply bytes with a running CRC16 into the output register.
`timescale 1ns / 1ps
`include "modbus_single_coil_responder_unit_defines.svh"

module msr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  msr_pkg::msr_cmd_t cmd,
  output logic              cmd_pop,
  msr_out_if.source         out_ch
);
  import msr_pkg::*;

  msr_cmd_t    cur_r;
  logic        active_r, active_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic        out_coil_r;
  logic        can_emit, emit, is_crc_lo, is_crc_hi;
  logic [7:0]  sel_byte;

  assign can_emit = !out_valid_r || out_ch.ready;
  assign emit = active_r && can_emit;
  assign cmd_pop = cmd_valid && !active_r;

  assign is_crc_lo = cur_r.has_crc && (idx_r == cur_r.crc_idx);
  assign is_crc_hi = cur_r.has_crc && (idx_r == cur_r.crc_idx + 3'd1);

  always_comb begin
    priority if (is_crc_lo) begin
      sel_byte = crc_r[7:0];
    end else if (is_crc_hi) begin
      sel_byte = crc_r[15:8];
    end else begin
      sel_byte = cur_r.data[idx_r];
    end
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    out_valid_nxt = out_valid_r;
    if (cmd_pop) begin
      active_nxt = 1'b1;
      idx_nxt = 3'd0;
      crc_nxt = CRC_INIT;
    end else if (emit) begin
      idx_nxt = idx_r + 3'd1;
      if (idx_r == cur_r.last_idx) begin
        active_nxt = 1'b0;
      end
      if (!is_crc_lo && !is_crc_hi) begin
        crc_nxt = crc16_byte(crc_r, sel_byte);
      end
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    crc_r <= crc_nxt;
    if (cmd_pop) begin
      cur_r <= cmd;
    end
    if (emit) begin
      out_byte_r <= sel_byte;
      out_last_r <= (idx_r == cur_r.last_idx);
      out_coil_r <= cur_r.coil;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.tx_byte = out_byte_r;
  assign out_ch.tx_last = out_last_r;
  assign out_ch.coil_level = out_coil_r;

  `MSR_ASSERT_IMP(a_idx_range, active_r, idx_r <= cur_r.last_idx)
  `MSR_ASSERT_NXT(a_last_ends, emit && (idx_r == cur_r.last_idx), !active_r && out_last_r)
  `MSR_ASSERT_NXT(a_out_hold, out_valid_r && !out_ch.ready, out_valid_r)

endmodule
